// ----- rtl/mtf_pkg.sv -----
// Shared types and constants for the move-to-front list.
// Request and status codes, sequencer states and the storage control group.
// No dependencies.
`default_nettype none

package mtf_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_DEL_FRONT = 3'd2,
    REQ_DEL_BACK  = 3'd3,
    REQ_SEARCH    = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT_KEY,
    S_DONE
  } state_t;

  // Control group from the sequencer to the list storage.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic head_dec;
    logic head_inc;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mtf_if.sv -----
// Valid/ready channels of the move-to-front list: request in, result out.
// Uses no package.
`default_nettype none

interface mtf_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface mtf_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] status;
  logic [4:0] entry_total;

  modport source (output valid, found, status, entry_total, input ready);
  modport sink   (input valid, found, status, entry_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/mtf_store.sv -----
// List storage: a circular buffer addressed by list position.
// Position 0 sits at the head pointer; depends on mtf_pkg for the control group.
`default_nettype none

module mtf_store #(
  parameter int CAPACITY = mtf_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mtf_pkg::store_ctl_t         ctl,
  input  wire logic [IW-1:0]               rd_pos,
  input  wire logic [IW-1:0]               wr_pos,
  input  wire logic [mtf_pkg::VALUE_W-1:0] wr_data,
  output logic      [mtf_pkg::VALUE_W-1:0] rd_data
);

  localparam logic [IW:0]   CAP_W  = (IW+1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_P = IW'(CAPACITY - 1);

  logic [mtf_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [IW:0]   rd_sum;
  logic [IW:0]   wr_sum;

  // Map position to slot: head + pos, wrapped once.
  always_comb begin
    rd_sum  = {1'b0, head} + {1'b0, rd_pos};
    wr_sum  = {1'b0, head} + {1'b0, wr_pos};
    rd_addr = (rd_sum >= CAP_W) ? IW'(rd_sum - CAP_W) : rd_sum[IW-1:0];
    wr_addr = (wr_sum >= CAP_W) ? IW'(wr_sum - CAP_W) : wr_sum[IW-1:0];
  end

  always_comb begin
    head_next = head;
    if (ctl.head_dec) begin
      head_next = (head == '0) ? LAST_P : head - IW'(1);
    end else if (ctl.head_inc) begin
      head_next = (head == LAST_P) ? '0 : head + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/move_to_front_list.sv -----
// Move-to-front list: top level with the request sequencer and result register.
// Depends on mtf_pkg, mtf_req_if / mtf_rsp_if and mtf_store.
//
//   channel | dir | payload                           | transfer when
//   --------+-----+-----------------------------------+----------------------
//   req     | in  | req_type[2:0], value[31:0]        | req.valid & req.ready
//   rsp     | out | found, status[1:0], entry_total[4:0] | rsp.valid & rsp.ready
//
// Inserts, deletes, clear, unused codes and a search of an empty list go straight
// from idle to the done state, which loads the result and returns to idle. A search
// reads and compares one entry at a time (scan read, scan compare), as there is one
// read port and one comparator; after a hit it shifts each entry ahead of the match
// down a place (move read, move write), puts the key at the front if any moved, then goes to done.
// req.ready is high only while the sequencer is idle and out of reset; a held result
// does not block the next request, which then waits in the done state for the slot.
// Reset empties the list; storage contents need no clearing.
`default_nettype none

module move_to_front_list #(
  parameter int CAPACITY = mtf_pkg::CAPACITY_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  mtf_req_if.sink    req,
  mtf_rsp_if.source  rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_P = IW'(CAPACITY - 1);

  mtf_pkg::state_t     state;
  mtf_pkg::state_t     state_next;
  mtf_pkg::store_ctl_t ctl;
  mtf_pkg::status_t    status_r;
  mtf_pkg::status_t    status_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic [31:0]   key;
  logic [31:0]   key_next;
  logic          found_r;
  logic          found_next;
  logic          res_load;
  logic          accept;
  logic          match;
  logic          last;

  logic [IW-1:0] rd_pos;
  logic [IW-1:0] wr_pos;
  logic [31:0]   wr_data;
  logic [31:0]   rd_data;
  logic [CW+4:0] total_ext;

  mtf_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_pos  (rd_pos),
    .wr_pos  (wr_pos),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign req.ready = (state == mtf_pkg::S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign match     = (rd_data == key);
  assign last      = ((CW'(idx) + CW'(1)) == count);
  assign res_load  = (state == mtf_pkg::S_DONE) && (!rsp.valid || rsp.ready);
  assign total_ext = {5'b0, count};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mtf_pkg::S_IDLE: begin
        if (accept) begin
          if (mtf_pkg::req_type_t'(req.req_type) == mtf_pkg::REQ_SEARCH && count != '0) begin
            state_next = mtf_pkg::S_SCAN_RD;
          end else begin
            state_next = mtf_pkg::S_DONE;
          end
        end
      end
      mtf_pkg::S_SCAN_RD:  state_next = mtf_pkg::S_SCAN_CMP;
      mtf_pkg::S_SCAN_CMP: begin
        if (match) begin
          state_next = (idx == '0) ? mtf_pkg::S_DONE : mtf_pkg::S_MOVE_RD;
        end else if (last) begin
          state_next = mtf_pkg::S_DONE;
        end else begin
          state_next = mtf_pkg::S_SCAN_RD;
        end
      end
      mtf_pkg::S_MOVE_RD: state_next = mtf_pkg::S_MOVE_WR;
      mtf_pkg::S_MOVE_WR: begin
        state_next = (idx == IW'(1)) ? mtf_pkg::S_PUT_KEY : mtf_pkg::S_MOVE_RD;
      end
      mtf_pkg::S_PUT_KEY: state_next = mtf_pkg::S_DONE;
      mtf_pkg::S_DONE: begin
        if (res_load) begin
          state_next = mtf_pkg::S_IDLE;
        end
      end
      default: state_next = mtf_pkg::S_IDLE;
    endcase
  end

  // Storage commands and datapath updates
  always_comb begin
    ctl         = '0;
    rd_pos      = idx;
    wr_pos      = idx;
    wr_data     = key;
    count_next  = count;
    idx_next    = idx;
    key_next    = key;
    found_next  = found_r;
    status_next = status_r;
    case (state)
      mtf_pkg::S_IDLE: begin
        if (accept) begin
          key_next    = req.value;
          found_next  = 1'b0;
          status_next = mtf_pkg::ST_OK;
          idx_next    = '0;
          case (mtf_pkg::req_type_t'(req.req_type))
            mtf_pkg::REQ_INS_FRONT: begin
              if (count < CAP_C) begin
                // Last position wraps to the slot just before the head.
                ctl.wr_en    = 1'b1;
                ctl.head_dec = 1'b1;
                wr_pos       = LAST_P;
                wr_data      = req.value;
                count_next   = count + CW'(1);
              end else begin
                status_next = mtf_pkg::ST_FULL;
              end
            end
            mtf_pkg::REQ_INS_BACK: begin
              if (count < CAP_C) begin
                ctl.wr_en  = 1'b1;
                wr_pos     = count[IW-1:0];
                wr_data    = req.value;
                count_next = count + CW'(1);
              end else begin
                status_next = mtf_pkg::ST_FULL;
              end
            end
            mtf_pkg::REQ_DEL_FRONT: begin
              if (count != '0) begin
                ctl.head_inc = 1'b1;
                count_next   = count - CW'(1);
              end else begin
                status_next = mtf_pkg::ST_EMPTY;
              end
            end
            mtf_pkg::REQ_DEL_BACK: begin
              if (count != '0) begin
                count_next = count - CW'(1);
              end else begin
                status_next = mtf_pkg::ST_EMPTY;
              end
            end
            mtf_pkg::REQ_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      mtf_pkg::S_SCAN_RD: begin
        ctl.rd_en = 1'b1;
        rd_pos    = idx;
      end
      mtf_pkg::S_SCAN_CMP: begin
        if (match) begin
          found_next = 1'b1;
        end else if (!last) begin
          idx_next = idx + IW'(1);
        end
      end
      mtf_pkg::S_MOVE_RD: begin
        ctl.rd_en = 1'b1;
        rd_pos    = idx - IW'(1);
      end
      mtf_pkg::S_MOVE_WR: begin
        // Shift the entry above down one place toward the tail.
        ctl.wr_en = 1'b1;
        wr_pos    = idx;
        wr_data   = rd_data;
        idx_next  = idx - IW'(1);
      end
      mtf_pkg::S_PUT_KEY: begin
        ctl.wr_en = 1'b1;
        wr_pos    = '0;
        wr_data   = key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtf_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    key      <= key_next;
    found_r  <= found_next;
    status_r <= status_next;
  end

  // Result register: hold until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.found       <= found_r;
      rsp.status      <= status_r;
      rsp.entry_total <= total_ext[4:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while previous one still in progress");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (rsp.status == mtf_pkg::ST_OK))
    else $error("found result carries an error status");

  a_empty_search: assert property (@(posedge clk) disable iff (rst)
    (accept && mtf_pkg::req_type_t'(req.req_type) == mtf_pkg::REQ_SEARCH && count == '0)
      |=> (state == mtf_pkg::S_DONE && !found_r))
    else $error("search on empty list did not finish at once");

endmodule

`default_nettype wire

// ----- dv/move_to_front_list_tb.sv -----
// Testbench for move_to_front_list: directed corner cases, then random request mixes.
// A shadow queue predicts each result, and the results are checked in order.
// Depends on mtf_pkg, mtf_req_if / mtf_rsp_if and the move_to_front_list RTL.
`timescale 1ns / 100ps

module move_to_front_list_tb;

  localparam int CAPACITY = mtf_pkg::CAPACITY_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 4 * CAPACITY + 8;

  // Request codes that the block must treat as no-ops
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    logic             found;
    mtf_pkg::status_t status;
    logic [4:0]       entry_total;
  } mtf_result_t;

  logic clk;
  logic rst;

  mtf_req_if req_ch ();
  mtf_rsp_if rsp_ch ();

  move_to_front_list #(.CAPACITY(CAPACITY)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [31:0] shadow_list[$];
  mtf_result_t        awaited_results[$];

  int  idle_pct;
  int  stall_pct;
  int  errors;
  int  requests_sent;
  int  results_seen;
  int  search_hits;
  int  search_misses;
  int  full_rejects;
  int  empty_deletes;
  bit  grow_list;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the result it must produce.
  function automatic mtf_result_t apply_request(input logic [2:0] kind,
                                                input logic signed [31:0] key);
    mtf_result_t r;
    r.found  = 1'b0;
    r.status = mtf_pkg::ST_OK;
    case (kind)
      mtf_pkg::REQ_INS_FRONT, mtf_pkg::REQ_INS_BACK: begin
        if (shadow_list.size() >= CAPACITY) begin
          r.status = mtf_pkg::ST_FULL;
          full_rejects++;
        end else if (kind == mtf_pkg::REQ_INS_FRONT) begin
          shadow_list.push_front(key);
        end else begin
          shadow_list.push_back(key);
        end
      end
      mtf_pkg::REQ_DEL_FRONT, mtf_pkg::REQ_DEL_BACK: begin
        if (shadow_list.size() == 0) begin
          r.status = mtf_pkg::ST_EMPTY;
          empty_deletes++;
        end else if (kind == mtf_pkg::REQ_DEL_FRONT) begin
          void'(shadow_list.pop_front());
        end else begin
          void'(shadow_list.pop_back());
        end
      end
      mtf_pkg::REQ_SEARCH: begin
        // first match from the head moves to the front
        for (int i = 0; i < shadow_list.size() && !r.found; i++) begin
          if (shadow_list[i] == key) begin
            shadow_list.delete(i);
            shadow_list.push_front(key);
            r.found = 1'b1;
          end
        end
        if (r.found) search_hits++;
        else search_misses++;
      end
      mtf_pkg::REQ_CLEAR: shadow_list.delete();
      default: ;
    endcase
    r.entry_total = 5'(shadow_list.size());
    return r;
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic signed [31:0] key);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_results.push_back(apply_request(kind, key));
    requests_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    mtf_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual found=%0d status=%0d total=%0d",
                 $time, rsp_ch.found, rsp_ch.status, rsp_ch.entry_total);
      end else begin
        want = awaited_results.pop_front();
        compare_field("found", want.found, rsp_ch.found);
        compare_field("status", want.status, rsp_ch.status);
        compare_field("entry_total", want.entry_total, rsp_ch.entry_total);
      end
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("move_to_front_list_tb failed");
    $finish;
  end

  // Mostly a few recurring values so that searches hit and duplicates occur.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return 32'sd7;
      4: return 32'sh7FFF_FFFF;
      5: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_corner_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(mtf_pkg::REQ_DEL_FRONT, 32'sd0);
    send_request(mtf_pkg::REQ_SEARCH, 32'sd0);
    send_request(REQ_SPARE_6, 32'sh5A5A_5A5A);
    send_request(REQ_SPARE_7, -32'sd1);
    send_request(mtf_pkg::REQ_INS_FRONT, 32'sh7FFF_FFFF);
    send_request(mtf_pkg::REQ_INS_BACK, 32'sh8000_0000);
    send_request(mtf_pkg::REQ_INS_FRONT, 32'sd0);
    send_request(mtf_pkg::REQ_INS_BACK, -32'sd1);
    send_request(mtf_pkg::REQ_SEARCH, 32'sd0);
    send_request(mtf_pkg::REQ_SEARCH, -32'sd1);
    send_request(mtf_pkg::REQ_SEARCH, 32'sd12345);
    // fill up, with every third insert a duplicate of 0
    for (int i = 0; i < CAPACITY - 4; i++)
      send_request((i % 2) ? mtf_pkg::REQ_INS_BACK : mtf_pkg::REQ_INS_FRONT,
                   (i % 3 == 0) ? 32'sd0 : $urandom);
    send_request(mtf_pkg::REQ_INS_FRONT, 32'sd99);
    send_request(mtf_pkg::REQ_INS_BACK, 32'sd99);
    send_request(mtf_pkg::REQ_CLEAR, 32'sd0);
    send_request(mtf_pkg::REQ_DEL_BACK, 32'sd0);
    wait_for_results();
  endtask

  task automatic test_random_mix(input int count, input int idle, input int stall);
    int                 roll;
    logic [2:0]         kind;
    logic signed [31:0] key;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      // swing between filling and draining so both full and empty get hit
      if ($urandom_range(39) == 0) grow_list = !grow_list;
      roll = $urandom_range(99);
      if (roll >= 98)                  kind = $urandom_range(1) ? REQ_SPARE_7 : REQ_SPARE_6;
      else if (roll == 97)             kind = mtf_pkg::REQ_CLEAR;
      else if (roll >= 70)             kind = mtf_pkg::REQ_SEARCH;
      else if (grow_list && roll < 30) kind = mtf_pkg::REQ_INS_FRONT;
      else if (grow_list && roll < 55) kind = mtf_pkg::REQ_INS_BACK;
      else if (grow_list && roll < 63) kind = mtf_pkg::REQ_DEL_FRONT;
      else if (grow_list)              kind = mtf_pkg::REQ_DEL_BACK;
      else if (roll < 8)               kind = mtf_pkg::REQ_INS_FRONT;
      else if (roll < 15)              kind = mtf_pkg::REQ_INS_BACK;
      else if (roll < 40)              kind = mtf_pkg::REQ_DEL_FRONT;
      else                             kind = mtf_pkg::REQ_DEL_BACK;
      if (kind == mtf_pkg::REQ_SEARCH && shadow_list.size() != 0 && $urandom_range(9) < 7)
        key = shadow_list[$urandom_range(shadow_list.size() - 1)];
      else
        key = pick_value();
      send_request(kind, key);
    end
    wait_for_results();
  endtask

  initial begin
    errors        = 0;
    requests_sent = 0;
    results_seen  = 0;
    search_hits   = 0;
    search_misses = 0;
    full_rejects  = 0;
    empty_deletes = 0;
    grow_list     = 1'b1;
    idle_pct      = 0;
    stall_pct     = 0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= mtf_pkg::REQ_INS_FRONT;
    req_ch.value    <= 32'sd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_cases();
    test_random_mix(350, 0, 0);
    test_random_mix(350, 76, 0);
    test_random_mix(350, 0, 76);
    test_random_mix(350, 24, 24);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d results) under four sender/receiver idle mixes.",
             requests_sent, results_seen);
    $display("Search hits %0d, misses %0d; inserts on full %0d; deletes on empty %0d.",
             search_hits, search_misses, full_rejects, empty_deletes);
    if (errors == 0) begin
      $display("move_to_front_list_tb passed");
    end else begin
      $display("move_to_front_list_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mtf_pkg.sv
rtl/mtf_if.sv
rtl/mtf_store.sv
rtl/move_to_front_list.sv
dv/move_to_front_list_tb.sv
